@@ hdl/srcor_pkg.sv @@
// ----------------------------------------------------------------------------
// srcor_pkg
// Shared types and constants for the rank correlation block.
// ----------------------------------------------------------------------------
package srcor_pkg;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TOO_FEW  = 2'd1;
    localparam logic [1:0] STATUS_DROPPED  = 2'd2;

    localparam int RHO_W = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RANK_I,
        ST_RANK_K,
        ST_RANK_END,
        ST_ACCUM,
        ST_DEN,
        ST_NUM,
        ST_DIV,
        ST_ROUND,
        ST_SAT,
        ST_OUT
    } calc_state_t;

    // item handed from the loader to the ranking engine
    typedef struct packed {
        logic [31:0] x_key;
        logic [31:0] y_key;
        logic        last_pair;
    } pair_item_t;

endpackage

@@ hdl/srcor_front.sv @@
// ----------------------------------------------------------------------------
// srcor_front
// Accepts sample pairs, flips the key sign bits and passes them through a two-entry queue.
// ----------------------------------------------------------------------------
module srcor_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  srcor_pkg::pair_item_t  in_item,
    output logic                   q_valid,
    input  logic                   q_ready,
    output srcor_pkg::pair_item_t  q_item
);

    srcor_pkg::pair_item_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            // flip sign bit so unsigned compare gives signed order
            mem_reg[wr_ptr_reg] <= '{x_key: in_item.x_key ^ 32'h8000_0000,
                                     y_key: in_item.y_key ^ 32'h8000_0000,
                                     last_pair: in_item.last_pair};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ hdl/srcor_back.sv @@
// ----------------------------------------------------------------------------
// srcor_back
// Stores pairs, ranks both series, sums squared differences and divides.
// ----------------------------------------------------------------------------
module srcor_back #(
    parameter int MAX_PAIRS = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  srcor_pkg::pair_item_t  q_item,
    output logic                   res_valid,
    input  logic                   res_ready,
    output logic [15:0]            res_rho,
    output logic [1:0]             res_status
);

    localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int CW = $clog2(MAX_PAIRS + 1);
    // widths for exact arithmetic: n < 2^CW
    localparam int DW = 3 * CW + 2;
    localparam int NW = DW + 16;
    localparam int RW = CW + 2;

    logic [31:0] xs_mem [MAX_PAIRS];
    logic [31:0] ys_mem [MAX_PAIRS];

    srcor_pkg::calc_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] i_reg, i_next, k_reg, k_next;
    logic [31:0]   xi_reg, yi_reg, xk_rd, yk_rd, xi_rd, yi_rd;
    logic [RW-1:0] xl_reg, xle_reg, yl_reg, yle_reg;
    logic [RW-1:0] xl_next, xle_next, yl_next, yle_next;
    logic [DW-1:0] dsum_reg, dsum_next;
    logic [DW-1:0] den_reg, den_next;
    logic [NW-1:0] num_reg, num_next;
    logic          neg_reg, neg_next;
    logic [NW:0]   rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [7:0]    bit_reg, bit_next;
    logic [15:0]   rho_reg, rho_next;
    logic [1:0]    stat_reg, stat_next;
    logic          rd_phase_reg, rd_phase_next;

    logic          wr_en;
    logic [AW-1:0] rd_addr;
    logic [RW-1:0] rx, ry, dd;
    logic [2*RW-1:0] dsq;
    logic [NW:0]   rem_sh;
    logic [NW-1:0] dsum6;
    logic [NW-1:0] den16;

    assign q_ready    = (state_reg == srcor_pkg::ST_IDLE);
    assign res_valid  = (state_reg == srcor_pkg::ST_OUT);
    assign res_rho    = rho_reg;
    assign res_status = stat_reg;
    assign wr_en      = q_valid && q_ready && (cnt_reg != CW'(MAX_PAIRS));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            xs_mem[cnt_reg[AW-1:0]] <= q_item.x_key;
            ys_mem[cnt_reg[AW-1:0]] <= q_item.y_key;
        end
        xk_rd <= xs_mem[rd_addr];
        yk_rd <= ys_mem[rd_addr];
    end
    assign xi_rd = xk_rd;
    assign yi_rd = yk_rd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srcor_pkg::ST_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg <= i_next; k_reg <= k_next;
        xl_reg <= xl_next; xle_reg <= xle_next;
        yl_reg <= yl_next; yle_reg <= yle_next;
        dsum_reg <= dsum_next; den_reg <= den_next; num_reg <= num_next;
        neg_reg <= neg_next; rem_reg <= rem_next; quo_reg <= quo_next;
        bit_reg <= bit_next; rho_reg <= rho_next; stat_reg <= stat_next;
        rd_phase_reg <= rd_phase_next;
        if (state_reg == srcor_pkg::ST_RANK_I && rd_phase_reg) begin
            xi_reg <= xi_rd;
            yi_reg <= yi_rd;
        end
    end

    assign rx  = xl_reg + xle_reg - RW'(1);
    assign ry  = yl_reg + yle_reg - RW'(1);
    assign dd  = (rx > ry) ? rx - ry : ry - rx;
    assign dsq = dd * dd;
    assign rem_sh = {rem_reg[NW-1:0], num_reg[NW-1]};
    assign dsum6  = NW'(dsum_reg) * NW'(6);
    assign den16  = NW'(den_reg) << 14;

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg; ovf_next = ovf_reg;
        i_next = i_reg; k_next = k_reg;
        xl_next = xl_reg; xle_next = xle_reg; yl_next = yl_reg; yle_next = yle_reg;
        dsum_next = dsum_reg; den_next = den_reg; num_next = num_reg;
        neg_next = neg_reg; rem_next = rem_reg; quo_next = quo_reg;
        bit_next = bit_reg; rho_next = rho_reg; stat_next = stat_reg;
        rd_phase_next = 1'b0;
        rd_addr = i_reg[AW-1:0];
        case (state_reg)
            srcor_pkg::ST_IDLE: begin
                if (q_valid) begin
                    if (cnt_reg != CW'(MAX_PAIRS)) cnt_next = cnt_reg + CW'(1);
                    else ovf_next = 1'b1;
                    if (q_item.last_pair) begin
                        i_next = '0;
                        dsum_next = '0;
                        state_next = srcor_pkg::ST_RANK_I;
                    end
                end
            end
            srcor_pkg::ST_RANK_I: begin
                if (cnt_reg < CW'(2)) begin
                    rho_next = '0;
                    stat_next = srcor_pkg::STATUS_TOO_FEW;
                    state_next = srcor_pkg::ST_OUT;
                end else if (!rd_phase_reg) begin
                    rd_phase_next = 1'b1;
                end else begin
                    k_next = '0;
                    xl_next = '0; xle_next = '0; yl_next = '0; yle_next = '0;
                    rd_addr = '0;
                    state_next = srcor_pkg::ST_RANK_K;
                end
            end
            srcor_pkg::ST_RANK_K: begin
                // read data for entry k arrives the cycle after its address is issued
                rd_addr = AW'(k_reg + CW'(1));
                if (xk_rd < xi_reg)  xl_next  = xl_reg + RW'(1);
                if (xk_rd <= xi_reg) xle_next = xle_reg + RW'(1);
                if (yk_rd < yi_reg)  yl_next  = yl_reg + RW'(1);
                if (yk_rd <= yi_reg) yle_next = yle_reg + RW'(1);
                k_next = k_reg + CW'(1);
                if (k_reg + CW'(1) == cnt_reg) state_next = srcor_pkg::ST_ACCUM;
            end
            srcor_pkg::ST_ACCUM: begin
                dsum_next = dsum_reg + DW'(dsq);
                i_next = i_reg + CW'(1);
                if (i_reg + CW'(1) == cnt_reg) state_next = srcor_pkg::ST_RANK_END;
                else state_next = srcor_pkg::ST_RANK_I;
            end
            srcor_pkg::ST_RANK_END: begin
                den_next = DW'(cnt_reg) * DW'(cnt_reg) - DW'(1);
                state_next = srcor_pkg::ST_DEN;
            end
            srcor_pkg::ST_DEN: begin
                den_next = DW'(den_reg * DW'(cnt_reg));
                // D = 4*sum; 6*sum*16384 = 6*D*4096
                state_next = srcor_pkg::ST_NUM;
            end
            srcor_pkg::ST_NUM: begin
                if ((dsum6 << 12) > (den16)) begin
                    neg_next = 1'b1;
                    num_next = (dsum6 << 12) - den16;
                end else begin
                    neg_next = 1'b0;
                    num_next = den16 - (dsum6 << 12);
                end
                rem_next = '0;
                quo_next = '0;
                bit_next = 8'(NW);
                state_next = srcor_pkg::ST_DIV;
            end
            srcor_pkg::ST_DIV: begin
                // restoring division, one quotient bit per cycle
                num_next = num_reg << 1;
                if (rem_sh >= (NW+1)'(den_reg)) begin
                    rem_next = rem_sh - (NW+1)'(den_reg);
                    quo_next = {quo_reg[NW-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[NW-2:0], 1'b0};
                end
                bit_next = bit_reg - 8'd1;
                if (bit_reg == 8'd1) state_next = srcor_pkg::ST_ROUND;
            end
            srcor_pkg::ST_ROUND: begin
                if ((rem_reg << 1) >= (NW+1)'(den_reg)) quo_next = quo_reg + NW'(1);
                state_next = srcor_pkg::ST_SAT;
            end
            srcor_pkg::ST_SAT: begin
                if (quo_reg > NW'(16384))
                    rho_next = neg_reg ? -16'sd16384 : 16'sd16384;
                else
                    rho_next = neg_reg ? 16'(-quo_reg[15:0]) : quo_reg[15:0];
                stat_next = ovf_reg ? srcor_pkg::STATUS_DROPPED : srcor_pkg::STATUS_OK;
                state_next = srcor_pkg::ST_OUT;
            end
            srcor_pkg::ST_OUT: begin
                if (res_ready) begin
                    cnt_next = '0;
                    ovf_next = 1'b0;
                    state_next = srcor_pkg::ST_IDLE;
                end
            end
            default: state_next = srcor_pkg::ST_IDLE;
        endcase
    end

endmodule

@@ hdl/srcor_out.sv @@
// ----------------------------------------------------------------------------
// srcor_out
// Output register stage holding one finished result.
// ----------------------------------------------------------------------------
module srcor_out (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [17:0] in_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [17:0] m_data
);

    logic        valid_reg;
    logic [17:0] data_reg;

    assign in_ready = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) data_reg <= in_data;
    end

endmodule

@@ hdl/spearman_rank_correlation_top.sv @@
// ----------------------------------------------------------------------------
// spearman_rank_correlation_top
// Rank correlation of a set of sample pairs, result in signed Q1.14.
// ----------------------------------------------------------------------------
// Pairs enter at one per cycle while the core is idle, through a small queue,
// and are stored in two memories. A pair with tlast closes the set; ranking
// then reads each memory once per compare through its single read port, and
// no new pair is stored until the result has been handed on.
module spearman_rank_correlation_top #(
    parameter int MAX_PAIRS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // x_sample, y_sample
    input  logic        s_tlast,   // last_pair
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // rho, status, zero fill
);

    srcor_pkg::pair_item_t in_item, q_item;
    logic q_valid, q_ready;
    logic res_valid, res_ready;
    logic [15:0] res_rho;
    logic [1:0]  res_status;
    logic [17:0] out_data;

    assign in_item = '{x_key: s_tdata[31:0], y_key: s_tdata[63:32],
                       last_pair: s_tlast};

    srcor_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    srcor_back #(.MAX_PAIRS(MAX_PAIRS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .res_valid(res_valid), .res_ready(res_ready),
        .res_rho(res_rho), .res_status(res_status)
    );

    srcor_out u_out (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(res_valid), .in_ready(res_ready), .in_data({res_status, res_rho}),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_data(out_data)
    );

    assign m_tdata = {6'd0, out_data};

endmodule

@@ hdl/srcor_checker.sv @@
// ----------------------------------------------------------------------------
// srcor_checker
// Port level checks for the rank correlation block.
// ----------------------------------------------------------------------------
module srcor_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped under stall");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[17:16] != 2'd3)
        else $error("bad status");

    a_few: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[17:16] == 2'd1 |-> m_tdata[15:0] == 16'd0)
        else $error("too few must give zero rho");

    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:18] == 6'd0)
        else $error("fill bits set");

    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown({s_tvalid, s_tready, m_tvalid}))
        else $error("handshake unknown");

endmodule

bind spearman_rank_correlation_top srcor_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

@@ bench/tb_spearman_rank_correlation_top.sv @@
// ----------------------------------------------------------------------------
// tb_spearman_rank_correlation_top
// Self-checking regression for the rank correlation block.
// ----------------------------------------------------------------------------
// Sets of sample pairs are streamed in; a behavioral rank correlation
// computes the expected rho and status of each set, and every result
// transaction is checked in order against it. Covers single and empty-like
// sets, ties, extremes, store overflow and random sets with random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_spearman_rank_correlation_top;

    localparam int MAX_PAIRS = 256;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] rho;
    } corr_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    logic [31:0]  x_keys [MAX_PAIRS];
    logic [31:0]  y_keys [MAX_PAIRS];
    int           held_pairs = 0;
    bit           dropped_seen = 0;
    corr_result_t expected_results[$];
    int           failures = 0;
    bit           calm = 0;
    longint       cycles = 0;

    spearman_rank_correlation_top #(.MAX_PAIRS(MAX_PAIRS)) dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint doubled_rank(input logic [31:0] keys [MAX_PAIRS], int n, int i);
        longint lo = 0, le = 0;
        for (int k = 0; k < n; k++) begin
            if (keys[k] < keys[i]) lo++;
            if (keys[k] <= keys[i]) le++;
        end
        return lo + le - 1;
    endfunction

    function automatic corr_result_t rank_correlation(int n);
        corr_result_t r;
        longint d_sum = 0, den, num, mag, q, d;
        den = longint'(n) * (longint'(n) * n - 1);
        for (int i = 0; i < n; i++) begin
            d = doubled_rank(x_keys, n, i) - doubled_rank(y_keys, n, i);
            d_sum += d * d;
        end
        num = 16384 * den - 24576 * d_sum;
        mag = num < 0 ? -num : num;
        q = (2 * mag + den) / (2 * den);
        if (q > 16384) q = 16384;
        r.rho = 16'(num < 0 ? -q : q);
        r.status = dropped_seen ? srcor_pkg::STATUS_DROPPED : srcor_pkg::STATUS_OK;
        return r;
    endfunction

    // predict effect of one accepted pair
    function automatic void predict_pair(logic [31:0] x, logic [31:0] y, logic last);
        corr_result_t r;
        if (held_pairs < MAX_PAIRS) begin
            x_keys[held_pairs] = x ^ 32'h8000_0000;
            y_keys[held_pairs] = y ^ 32'h8000_0000;
            held_pairs++;
        end else begin
            dropped_seen = 1;
        end
        if (last) begin
            if (held_pairs < 2) begin
                r.rho = '0;
                r.status = srcor_pkg::STATUS_TOO_FEW;
            end else begin
                r = rank_correlation(held_pairs);
            end
            expected_results = {expected_results, r};
            held_pairs = 0;
            dropped_seen = 0;
        end
    endfunction

    task automatic send_pair(logic [31:0] x, logic [31:0] y, logic last);
        while (!calm && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y, x};
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        predict_pair(x, y, last);
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (aresetn) m_tready <= calm || ($urandom_range(99) >= 24);
    end

    always @(posedge aclk) begin
        corr_result_t got, want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("spearman_rank_correlation_top regression: fail");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[17:0];
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction rho=%0d status=%0d",
                       got.rho, got.status);
                failures++;
            end else begin
                want = expected_results.pop_front();
                if (got.rho !== want.rho) begin
                    $error("rho expected %0d actual %0d", want.rho, got.rho);
                    failures++;
                end
                if (got.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    failures++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_sample(int spread);
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(2 * spread)) - spread);
            2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom_range(spread);
        endcase
    endfunction

    task automatic send_set(int n, int spread);
        for (int i = 0; i < n; i++)
            send_pair(rand_sample(spread), rand_sample(spread), i == n - 1);
    endtask

    task automatic test_directed();
        send_pair(32'd5, 32'd7, 1'b1);
        send_pair(32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_pair(32'h7fff_ffff, 32'h8000_0000, 1'b1);
        for (int i = 0; i < 4; i++) send_pair(i, i, i == 3);
        for (int i = 0; i < 4; i++) send_pair(i, 3 - i, i == 3);
        for (int i = 0; i < 5; i++) send_pair(32'hffff_ffff, 32'(i[1:0]), i == 4);
        for (int i = 0; i < 5; i++) send_pair(i / 2, -i, i == 4);
    endtask

    task automatic test_overflow();
        for (int i = 0; i < MAX_PAIRS + 3; i++)
            send_pair($urandom(), $urandom(), i == MAX_PAIRS + 2);
        for (int i = 0; i < MAX_PAIRS; i++)
            send_pair(i, $urandom_range(20), 1'b0);
        send_pair(32'd1, 32'd2, 1'b1);
        send_pair(32'd9, 32'd9, 1'b1);
    endtask

    task automatic test_random(int budget);
        int sent = 0, n;
        while (sent < budget) begin
            calm = (sent > budget / 2) && (sent < budget / 2 + 120);
            n = $urandom_range(99) < 10 ? $urandom_range(1) + 1 : $urandom_range(3, 14);
            send_set(n, $urandom_range(1) ? 4 : 1000);
            sent += n;
        end
        calm = 0;
    endtask

    task automatic drain(int settle);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_overflow();
        test_random(700);
        drain(400);
        if (failures == 0)
            $display("spearman_rank_correlation_top regression: pass");
        else
            $display("spearman_rank_correlation_top regression: fail");
        $finish;
    end

endmodule
